FILE: rtl/xtk_pkg.sv
// ============================================================================
// xtk_pkg
// Shared constants, status codes and controller/datapath handshake types for
// the xor trie k-th maximum block.
// ============================================================================
`default_nettype none

package xtk_pkg;

    localparam int KEY_W         = 32;
    localparam int RANK_W        = 16;
    localparam int STATUS_W      = 2;

    localparam int KEY_BITS_DEF  = 32;
    localparam int NODE_POOL_DEF = 65536;
    localparam int MAX_KEYS_DEF  = 65535;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic check;
        logic root_rd;
        logic root_ld;
        logic step;
        logic load;
        logic wlast;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic bad;
        logic child_missing;
        logic last_level;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/xtk_in_if.sv
// ============================================================================
// xtk_in_if
// Request channel: one word carries an opcode, a key and a rank.
// ============================================================================
`default_nettype none

interface xtk_in_if
    import xtk_pkg::*;
();

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;

    modport source (output valid, output opcode, output key, output rank, input ready);
    modport sink   (input valid, input opcode, input key, input rank, output ready);

endinterface

`default_nettype wire

FILE: rtl/xtk_out_if.sv
// ============================================================================
// xtk_out_if
// Response channel: one word carries an xor value and a status code.
// ============================================================================
`default_nettype none

interface xtk_out_if
    import xtk_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    xor_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output xor_value, output status, input ready);
    modport sink   (input valid, input xor_value, input status, output ready);

endinterface

`default_nettype wire

FILE: rtl/xtk_ram.sv
// ============================================================================
// xtk_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module xtk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: rtl/xtk_ctrl.sv
// ============================================================================
// xtk_ctrl
// Sequencer: accepts a word, checks limits, walks the trie level by level
// and hands the result to the output register.
// ============================================================================
`default_nettype none

module xtk_ctrl
    import xtk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic valid,
    output logic      ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_ROOT_RD = 8'b0000_0100,
        S_ROOT_LD = 8'b0000_1000,
        S_STEP    = 8'b0001_0000,
        S_LOAD    = 8'b0010_0000,
        S_WLAST   = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = sts.bad ? S_FIN : S_ROOT_RD;
            end
            S_ROOT_RD:
            begin
                state_next = S_ROOT_LD;
            end
            S_ROOT_LD:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.is_query || !sts.child_missing)
                begin
                    state_next = S_LOAD;
                end
                else if (sts.last_level)
                begin
                    state_next = S_WLAST;
                end
            end
            S_LOAD:
            begin
                if (sts.last_level)
                begin
                    state_next = sts.is_query ? S_FIN : S_WLAST;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_WLAST:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ready       = (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && valid;
    assign cmd.check   = (state_reg == S_CHECK);
    assign cmd.root_rd = (state_reg == S_ROOT_RD);
    assign cmd.root_ld = (state_reg == S_ROOT_LD);
    assign cmd.step    = (state_reg == S_STEP);
    assign cmd.load    = (state_reg == S_LOAD);
    assign cmd.wlast   = (state_reg == S_WLAST);
    assign cmd.finish  = (state_reg == S_FIN) && sts.out_free;

endmodule

`default_nettype wire

FILE: rtl/xtk_dp.sv
// ============================================================================
// xtk_dp
// Datapath: node memory {child_one, child_zero, pass_count}, walk registers,
// key/store counters and the output register.
// ============================================================================
`default_nettype none

module xtk_dp
    import xtk_pkg::*;
#(
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int NODE_POOL = NODE_POOL_DEF,
    parameter int MAX_KEYS  = MAX_KEYS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic                opcode,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [RANK_W-1:0]   rank,
    input  wire logic                rsp_ready,
    output logic                     rsp_valid,
    output logic      [KEY_W-1:0]    xor_value,
    output logic      [STATUS_W-1:0] status
);

    localparam int AW  = $clog2(NODE_POOL);
    localparam int CW  = $clog2(MAX_KEYS + 1);
    localparam int WW  = 2 * AW + CW;
    localparam int LVW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int KXW = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
    localparam int MW  = (CW > RANK_W) ? CW : RANK_W;
    localparam int PW  = AW + 1;

    localparam logic [AW-1:0] NULL_NODE = '0;
    localparam logic [AW-1:0] ROOT_NODE = AW'(1);

    // walk and payload registers
    opcode_t            op_reg,     op_next;
    logic [KEY_BITS-1:0] key_reg,   key_next;
    logic [RANK_W-1:0]  rank_reg,   rank_next;
    logic [KEY_BITS-1:0] res_reg,   res_next;
    status_t            status_reg, status_next;
    logic [LVW-1:0]     lvl_reg,    lvl_next;
    logic [AW-1:0]      x_reg,      x_next;
    logic [WW-1:0]      wx_reg,     wx_next;
    logic [AW-1:0]      raddr_a_reg;
    logic [AW-1:0]      raddr_b_reg;
    logic [KEY_W-1:0]   out_xor_reg, out_xor_next;
    status_t            out_status_reg, out_status_next;

    // control registers
    logic [AW-1:0]      last_reg,   last_next;
    logic [CW-1:0]      stored_reg, stored_next;
    logic               root_valid_reg, root_valid_next;
    logic               out_valid_reg,  out_valid_next;

    // memory ports
    logic               we;
    logic [AW-1:0]      waddr;
    logic [WW-1:0]      wdata;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic [WW-1:0]      rdata_a;
    logic [WW-1:0]      rdata_b;

    logic [KXW-1:0]     key_ext;
    logic [KXW-1:0]     res_ext;
    logic               is_query;
    logic               cur_bit;
    logic               want;
    logic [AW-1:0]      wx_c0, wx_c1, nx;
    logic [CW-1:0]      wx_cnt;
    logic               child_missing;
    logic               last_level;
    logic               pool_low, key_full, rank_bad, bad;
    logic [WW-1:0]      a_word, b_word, pref_word, oth_word;
    logic [AW-1:0]      pref_addr, oth_addr;
    logic [CW-1:0]      pref_cnt;
    logic               take_pref;
    logic [MW-1:0]      rank_sub;
    logic [AW-1:0]      new_node;
    logic [WW-1:0]      wx_linked, fresh_word, inc_word;
    logic               out_free;

    xtk_ram #(
        .WIDTH (WW),
        .DEPTH (NODE_POOL)
    ) u_node_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    assign key_ext  = KXW'(key);
    assign res_ext  = KXW'(res_reg);
    assign is_query = (op_reg == OP_QUERY);

    assign wx_c1  = wx_reg[WW-1 -: AW];
    assign wx_c0  = wx_reg[WW-AW-1 -: AW];
    assign wx_cnt = wx_reg[CW-1:0];

    assign cur_bit       = key_reg[lvl_reg];
    assign want          = ~cur_bit;
    assign nx            = cur_bit ? wx_c1 : wx_c0;
    assign child_missing = (nx == NULL_NODE);
    assign last_level    = (lvl_reg == '0);

    assign pool_low = ({1'b0, last_reg} + PW'(KEY_BITS)) >= PW'(NODE_POOL);
    assign key_full = stored_reg >= CW'(MAX_KEYS);
    assign rank_bad = (rank_reg == '0) || (MW'(rank_reg) > MW'(stored_reg));
    assign bad      = is_query ? rank_bad : (key_full || pool_low);

    // null node, and the root before its first write, read as all zero
    assign a_word = ((raddr_a_reg == NULL_NODE) ||
                     ((raddr_a_reg == ROOT_NODE) && !root_valid_reg)) ? '0 : rdata_a;
    assign b_word = ((raddr_b_reg == NULL_NODE) ||
                     ((raddr_b_reg == ROOT_NODE) && !root_valid_reg)) ? '0 : rdata_b;

    assign pref_word = want ? b_word : a_word;
    assign oth_word  = want ? a_word : b_word;
    assign pref_addr = want ? wx_c1 : wx_c0;
    assign oth_addr  = want ? wx_c0 : wx_c1;
    assign pref_cnt  = pref_word[CW-1:0];
    assign take_pref = MW'(pref_cnt) >= MW'(rank_reg);
    assign rank_sub  = MW'(rank_reg) - MW'(pref_cnt);

    assign new_node   = last_reg + AW'(1);
    assign wx_linked  = cur_bit ? {new_node, wx_c0, wx_cnt} : {wx_c1, new_node, wx_cnt};
    assign fresh_word = {{(2 * AW){1'b0}}, CW'(1)};
    assign inc_word   = {a_word[WW-1:CW], a_word[CW-1:0] + CW'(1)};

    assign we      = (cmd.step && !is_query) || cmd.wlast;
    assign waddr   = x_reg;
    assign wdata   = (cmd.step && child_missing) ? wx_linked : wx_reg;
    assign raddr_a = cmd.root_rd ? ROOT_NODE : (is_query ? wx_c0 : nx);
    assign raddr_b = wx_c1;

    assign out_free = !out_valid_reg || rsp_ready;

    assign sts.is_query      = is_query;
    assign sts.bad           = bad;
    assign sts.child_missing = child_missing;
    assign sts.last_level    = last_level;
    assign sts.out_free      = out_free;

    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        rank_next       = rank_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        lvl_next        = lvl_reg;
        x_next          = x_reg;
        wx_next         = wx_reg;
        last_next       = last_reg;
        stored_next     = stored_reg;
        root_valid_next = root_valid_reg;
        out_valid_next  = out_valid_reg;
        out_xor_next    = out_xor_reg;
        out_status_next = out_status_reg;

        if (cmd.capture)
        begin
            op_next   = opcode_t'(opcode);
            key_next  = key_ext[KEY_BITS-1:0];
            rank_next = rank;
            res_next  = '0;
        end

        if (cmd.check)
        begin
            if (bad)
            begin
                status_next = is_query ? ST_RANGE : ST_REJECT;
            end
            else
            begin
                status_next = ST_OK;
            end
        end

        if (cmd.root_ld)
        begin
            x_next   = ROOT_NODE;
            wx_next  = a_word;
            lvl_next = LVW'(KEY_BITS - 1);
        end

        if (cmd.step && !is_query)
        begin
            if (child_missing)
            begin
                x_next    = new_node;
                wx_next   = fresh_word;
                last_next = new_node;
                if (!last_level)
                begin
                    lvl_next = lvl_reg - LVW'(1);
                end
            end
            else
            begin
                x_next = nx;
            end
        end

        if (cmd.load)
        begin
            if (is_query)
            begin
                if (take_pref)
                begin
                    x_next            = pref_addr;
                    wx_next           = pref_word;
                    res_next[lvl_reg] = 1'b1;
                end
                else
                begin
                    rank_next = rank_sub[RANK_W-1:0];
                    x_next    = oth_addr;
                    wx_next   = oth_word;
                end
            end
            else
            begin
                wx_next = inc_word;
            end
            if (!last_level)
            begin
                lvl_next = lvl_reg - LVW'(1);
            end
        end

        if (cmd.wlast)
        begin
            stored_next = stored_reg + CW'(1);
        end

        if (we && (waddr == ROOT_NODE))
        begin
            root_valid_next = 1'b1;
        end

        if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            out_xor_next    = res_ext[KEY_W-1:0];
            out_status_next = status_reg;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg       <= ROOT_NODE;
            stored_reg     <= '0;
            root_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_reg       <= last_next;
            stored_reg     <= stored_next;
            root_valid_reg <= root_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        rank_reg       <= rank_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        lvl_reg        <= lvl_next;
        x_reg          <= x_next;
        wx_reg         <= wx_next;
        raddr_a_reg    <= raddr_a;
        raddr_b_reg    <= raddr_b;
        out_xor_reg    <= out_xor_next;
        out_status_reg <= out_status_next;
    end

    assign rsp_valid = out_valid_reg;
    assign xor_value = out_xor_reg;
    assign status    = out_status_reg;

endmodule

`default_nettype wire

FILE: rtl/xor_trie_kth_max.sv
// ============================================================================
// xor_trie_kth_max
// Binary trie over keys with per-node pass counts: insert a key, or find the
// rank-th largest xor of a key against all stored keys.
// ============================================================================
// Usage:
//   req  (valid/ready): opcode (insert / query), key, rank. One word at a time;
//        ready is high only while the sequencer is idle.
//   rsp  (valid/ready): xor_value and status, one word per request.
// Sequence: a rejected or out-of-range word goes from the limit check
//   straight to the output register; a query or insert reads the root and
//   walks the trie from the top key bit down.
//   Each trie level costs a node memory read (registered) plus a decision
//   step; an insert level that allocates a new node needs no read.
// A new word is taken only once the last reaches the output register.
// Reset: trie empty, root preallocated. No clearing sweep: the null node and
//   the root before its first write read as zero, and every other node is
//   written when it is allocated.
// Stall: a finished response waits in the output register; the next request
//   is still accepted and walks the trie, then holds until rsp is taken.
// ============================================================================
`default_nettype none

module xor_trie_kth_max
    import xtk_pkg::*;
#(
    parameter int KEY_BITS  = KEY_BITS_DEF,
    parameter int NODE_POOL = NODE_POOL_DEF,
    parameter int MAX_KEYS  = MAX_KEYS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    xtk_in_if.sink     req,
    xtk_out_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;
    logic ready;

    xtk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (req.valid),
        .ready (ready),
        .sts   (sts),
        .cmd   (cmd)
    );

    xtk_dp #(
        .KEY_BITS  (KEY_BITS),
        .NODE_POOL (NODE_POOL),
        .MAX_KEYS  (MAX_KEYS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (req.opcode),
        .key       (req.key),
        .rank      (req.rank),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .xor_value (rsp.xor_value),
        .status    (rsp.status)
    );

    assign req.ready = ready;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while previous word still in flight");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp.valid || rsp.ready))
        else $error("pending response overwritten");

endmodule

`default_nettype wire

FILE: tb/xor_trie_kth_max_test.sv
`timescale 1ns / 1ps
// ============================================================================
// xor_trie_kth_max_test
// Self-checking bench for the xor trie k-th maximum block. A shadow trie
// predicts every response word. The run covers empty-trie and extreme-key
// cases, random insert/query traffic with random gaps on both channels, and
// a long response stall.
// ============================================================================
module xor_trie_kth_max_test;
    import xtk_pkg::*;

    localparam int HANG_LIMIT = 2000;

    typedef struct {
        logic [KEY_W-1:0] xor_value;
        status_t          status;
    } xor_result_t;

    logic clk;
    logic rst_n;

    xtk_in_if  req_if ();
    xtk_out_if rsp_if ();

    xor_trie_kth_max u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow trie
    int unsigned zero_link [NODE_POOL_DEF];
    int unsigned one_link  [NODE_POOL_DEF];
    int unsigned hits      [NODE_POOL_DEF];
    int          top_node = 1;
    int unsigned key_total = 0;

    xor_result_t      pending_results [$];
    logic [KEY_W-1:0] inserted_keys [$];
    int               mismatch_count = 0;
    bit               send_idle = 1'b1;
    bit               recv_idle = 1'b1;
    int               hold_req = 0;

    function automatic status_t trie_insert(logic [KEY_W-1:0] k);
        int unsigned node;
        int unsigned nxt;
        if (key_total >= MAX_KEYS_DEF)
            return ST_REJECT;
        if (NODE_POOL_DEF - 1 - top_node < KEY_BITS_DEF)
            return ST_REJECT;
        node = 1;
        for (int i = KEY_BITS_DEF - 1; i >= 0; i--)
        begin
            nxt = k[i] ? one_link[node] : zero_link[node];
            if (nxt == 0)
            begin
                top_node++;
                nxt = top_node;
                if (k[i])
                    one_link[node] = nxt;
                else
                    zero_link[node] = nxt;
            end
            node = nxt;
            hits[node]++;
        end
        key_total++;
        return ST_OK;
    endfunction

    function automatic logic [KEY_W-1:0] trie_kth(logic [KEY_W-1:0] k, int unsigned r);
        int unsigned      node;
        int unsigned      pref;
        logic [KEY_W-1:0] res;
        node = 1;
        res  = '0;
        for (int i = KEY_BITS_DEF - 1; i >= 0; i--)
        begin
            pref = k[i] ? zero_link[node] : one_link[node];
            if (hits[pref] >= r)
            begin
                node   = pref;
                res[i] = 1'b1;
            end
            else
            begin
                r    = r - hits[pref];
                node = k[i] ? one_link[node] : zero_link[node];
            end
        end
        return res;
    endfunction

    function automatic xor_result_t trie_predict(opcode_t op, logic [KEY_W-1:0] k,
                                                 logic [RANK_W-1:0] r);
        xor_result_t res;
        res.xor_value = '0;
        if (op == OP_INSERT)
            res.status = trie_insert(k);
        else if (r == 0 || r > key_total)
            res.status = ST_RANGE;
        else
        begin
            res.status    = ST_OK;
            res.xor_value = trie_kth(k, 32'(r));
        end
        return res;
    endfunction

    // mostly short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 4);
        return $urandom_range(5, 90);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int p;
        p = $urandom_range(0, 99);
        if (inserted_keys.size() == 0 || p < 45)
            return $urandom;
        if (p < 70)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        if (p < 90)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]
                   ^ (32'h1 << $urandom_range(0, KEY_W - 1));
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [RANK_W-1:0] pick_rank();
        int p;
        p = $urandom_range(0, 99);
        if (key_total == 0 || p < 10)
            return p[0] ? '0 : RANK_W'($urandom);
        if (p < 45)
            return RANK_W'($urandom_range(1, (key_total < 4) ? key_total : 4));
        if (p < 80)
            return RANK_W'($urandom_range(1, key_total));
        if (p < 90)
            return RANK_W'(key_total + 1);
        return RANK_W'($urandom);
    endfunction

    task automatic send_word(opcode_t op, logic [KEY_W-1:0] k, logic [RANK_W-1:0] r);
        int gap;
        gap = send_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.key    <= k;
        req_if.rank   <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_results.push_back(trie_predict(op, k, r));
        if (op == OP_INSERT)
            inserted_keys.push_back(k);
    endtask

    task automatic test_empty_trie();
        send_word(OP_QUERY, 32'h0000_0000, 16'd1);
        send_word(OP_QUERY, 32'hFFFF_FFFF, 16'd0);
        send_word(OP_QUERY, 32'h1234_5678, 16'hFFFF);
    endtask

    task automatic test_extremes();
        send_word(OP_INSERT, 32'h0000_0000, 16'hFFFF);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 16'd0);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 16'd7);
        send_word(OP_INSERT, 32'h8000_0000, 16'd0);
        send_word(OP_INSERT, 32'h0000_0001, 16'd0);
        send_word(OP_INSERT, 32'h7FFF_FFFF, 16'd0);
        send_word(OP_QUERY, 32'h0000_0000, 16'd1);
        send_word(OP_QUERY, 32'h0000_0000, 16'd6);
        send_word(OP_QUERY, 32'h0000_0000, 16'd7);
        send_word(OP_QUERY, 32'h0000_0000, 16'd0);
        send_word(OP_QUERY, 32'hFFFF_FFFF, 16'd1);
        send_word(OP_QUERY, 32'hFFFF_FFFF, 16'd3);
        send_word(OP_QUERY, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(OP_QUERY, 32'hA5A5_A5A5, 16'd2);
        send_word(OP_QUERY, 32'h5A5A_5A5A, 16'd4);
        send_word(OP_QUERY, 32'h8000_0000, 16'd5);
    endtask

    task automatic test_random_traffic(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
            begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < 40)
                send_word(OP_INSERT, pick_key(), RANK_W'($urandom));
            else
                send_word(OP_QUERY, pick_key(), pick_rank());
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // response side held off while requests keep coming
    task automatic test_response_stall();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_req  = 400;
        for (int n = 0; n < 6; n++)
        begin
            if (n[0])
                send_word(OP_QUERY, pick_key(), pick_rank());
            else
                send_word(OP_INSERT, pick_key(), RANK_W'($urandom));
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // response checker and ready driver
    initial
    begin
        int          stall_left;
        xor_result_t want;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected response word: xor_value %0h status %0d",
                           rsp_if.xor_value, rsp_if.status);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_if.xor_value !== want.xor_value)
                    begin
                        $error("xor_value: expected %0h, actual %0h",
                               want.xor_value, rsp_if.xor_value);
                        mismatch_count++;
                    end
                    if (rsp_if.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, rsp_if.status);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left == 0 && hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.opcode <= OP_INSERT;
        req_if.key    <= '0;
        req_if.rank   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_trie();
        test_extremes();
        test_random_traffic(1350);
        test_response_stall();
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * KEY_BITS_DEF + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
